FILE: hw/rtl/lsb_stego_payload_extractor_assert.svh
// assertion macros shared by the payload extractor checker
// no dependencies; included by name from the checker file
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LSPE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lspe property violated");

// next-cycle implication, disabled while reset is low
`define LSPE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lspe property violated");

`endif

FILE: hw/rtl/lspe_pkg.sv
// types, codes and defaults for the lsb stego payload extractor
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package lspe_pkg;

  // default sizes of the hidden stream fields
  localparam int unsigned MAGIC_MAX_BYTES = 8;
  localparam int unsigned MAX_EXTENSION   = 4;
  localparam int unsigned SIZE_BITS       = 32;

  // stream payload widths
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TDATA_W = 8;
  localparam int unsigned M_TUSER_W = 5;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SKIP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_BYTES  = 2'd2;

  localparam logic [15:0] HEADER_SKIP_RST  = 16'd54;
  localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
  localparam logic [63:0] MAGIC_BYTES_RST  = 64'd0;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_MAGIC  = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_EXT    = 3'd3,
    PH_SIZE   = 3'd4,
    PH_DATA   = 3'd5,
    PH_END    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_EXT    = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DONE     = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_BADEXT   = 3'd3,
    ST_TRUNC    = 3'd4
  } status_e;

  // one result transaction; fields from the lowest tuser bit up: kind, status
  typedef struct packed {
    logic    last;
    status_e status;
    kind_e   kind;
    logic [7:0] out_byte;
  } res_t;

endpackage

FILE: hw/rtl/lsb_stego_payload_extractor.sv
// lsb steganography payload extractor, top level
// depends on lspe_pkg
`timescale 1ns / 1ps

// Usage
//   s_axis carries one cover image byte per transaction: tdata[7:0] is the
//   byte (only bit 0 is read), tuser is the end-of-image flag. Raising tuser
//   ends the image; the block then reports truncation unless already done.
//   m_axis carries zero or one result per accepted transaction: the decoded
//   extension or payload character in tdata, kind and status in tuser, and
//   tlast on the final payload byte or on any terminal status.
//   Configuration (header skip, magic length, magic bytes) is written through
//   cfg_we_i / cfg_index_i / cfg_data_i while the stream is idle.
// Timing
//   one image byte per clock while s_axis_tready is high; all decode work happens
//   in the accepting cycle, whose edge registers the result for m_axis.
//   an output register plus a one-entry skid buffer decouple the sides, so
//   s_axis_tready is a register: it drops only once a stalled result sits in
//   the output register and a second one has gone to the skid stage.
// Reset
//   decode restarts in the header skip phase with all counters cleared and the
//   registers back to skip 54, magic length 2, magic bytes zero. After a
//   terminal result every further transaction is taken and dropped.

module lsb_stego_payload_extractor #(
  parameter int unsigned MagicMaxBytes = lspe_pkg::MAGIC_MAX_BYTES,
  parameter int unsigned MaxExtension  = lspe_pkg::MAX_EXTENSION,
  parameter int unsigned SizeBits      = lspe_pkg::SIZE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [lspe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lspe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // image byte stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lspe_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [7:0] image_byte
  input  logic [lspe_pkg::S_TUSER_W-1:0]      s_axis_tuser,  // [0] stream_end
  // decoded result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lspe_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // [7:0] out_byte
  output logic [lspe_pkg::M_TUSER_W-1:0]      m_axis_tuser,  // [1:0] kind, [4:2] status
  output logic                                m_axis_tlast   // last
);

  import lspe_pkg::*;

  localparam int unsigned CntW = $clog2(SizeBits);

  // configuration registers
  logic [15:0] header_skip_q;
  logic [3:0]  magic_length_q;
  logic [63:0] magic_bytes_q;

  // decode state
  phase_e              phase_q, phase_d;
  logic [15:0]         header_count_q, header_count_d;
  logic [CntW-1:0]     bit_count_q, bit_count_d;
  logic [SizeBits-1:0] bit_shift_q, bit_shift_d;
  logic [SizeBits-1:0] field_count_q, field_count_d;

  // output register and skid stage
  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;

  // per-transaction decode signals
  logic                in_fire;
  logic                in_bit;
  logic                in_end;
  logic                header_wait;
  logic [3:0]          magic_len_eff;
  phase_e              eff_phase;
  logic [CntW-1:0]     eff_bit_count;
  logic [SizeBits-1:0] eff_shift;
  logic [SizeBits-1:0] eff_field;
  logic [SizeBits-1:0] shift_next;
  logic                wide_field;
  logic                word_done;
  logic [7:0]          ch;
  logic [2:0]          magic_idx;
  logic [7:0]          magic_expect;
  logic                magic_ok;
  logic [SizeBits-1:0] field_inc;
  logic [SizeBits-1:0] field_dec;
  logic                magic_last;
  logic                ext_bad;
  logic                res_valid;
  res_t                res;
  logic                out_taken;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_bit  = s_axis_tdata[0];
  assign in_end  = s_axis_tuser[0];

  // ---------------------------------------------------------------------------
  // configuration writes, effective at once
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_skip_q  <= HEADER_SKIP_RST;
      magic_length_q <= MAGIC_LENGTH_RST;
      magic_bytes_q  <= MAGIC_BYTES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HEADER_SKIP:  header_skip_q  <= cfg_data_i[15:0];
        CFG_MAGIC_LENGTH: magic_length_q <= cfg_data_i[3:0];
        CFG_MAGIC_BYTES:  magic_bytes_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shared decode terms
  // ---------------------------------------------------------------------------
  // magic length saturates at the widest magic the block compares
  assign magic_len_eff = (magic_length_q > 4'(MagicMaxBytes)) ? 4'(MagicMaxBytes)
                                                               : magic_length_q;
  assign header_wait = (phase_q == PH_HEADER) && (header_count_q < header_skip_q);

  // the first hidden bit leaves the header phase and starts from clean counters
  always_comb begin
    if (phase_q == PH_HEADER) begin
      eff_phase     = (magic_len_eff == 4'd0) ? PH_EXTLEN : PH_MAGIC;
      eff_bit_count = '0;
      eff_shift     = '0;
      eff_field     = '0;
    end else begin
      eff_phase     = phase_q;
      eff_bit_count = bit_count_q;
      eff_shift     = bit_shift_q;
      eff_field     = field_count_q;
    end
  end

  // msb first: the new bit enters at the bottom
  assign shift_next = {eff_shift[SizeBits-2:0], in_bit};
  assign wide_field = (eff_phase == PH_EXTLEN) || (eff_phase == PH_SIZE);
  assign word_done  = wide_field ? (eff_bit_count == CntW'(SizeBits - 1))
                                 : (eff_bit_count == CntW'(7));
  assign ch         = shift_next[7:0];

  // magic character i sits in bits 63-8i downto 56-8i
  assign magic_idx    = eff_field[2:0];
  assign magic_expect = magic_bytes_q[{~magic_idx, 3'b000} +: 8];
  assign magic_ok     = (ch == magic_expect);

  assign field_inc  = eff_field + SizeBits'(1);
  assign field_dec  = eff_field - SizeBits'(1);
  assign magic_last = (field_inc >= SizeBits'(magic_len_eff));
  assign ext_bad    = (shift_next > SizeBits'(MaxExtension));

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    bit_count_d    = bit_count_q;
    bit_shift_d    = bit_shift_q;
    field_count_d  = field_count_q;
    if (in_fire && (phase_q != PH_END)) begin
      if (in_end) begin
        phase_d = PH_END;
      end else if (header_wait) begin
        header_count_d = header_count_q + 16'd1;
      end else begin
        phase_d       = eff_phase;
        field_count_d = eff_field;
        bit_shift_d   = shift_next;
        bit_count_d   = eff_bit_count + CntW'(1);
        if (word_done) begin
          bit_count_d = '0;
          bit_shift_d = '0;
          case (eff_phase)
            PH_MAGIC: begin
              if (!magic_ok) begin
                phase_d = PH_END;
              end else begin
                field_count_d = field_inc;
                if (magic_last) begin
                  phase_d       = PH_EXTLEN;
                  field_count_d = '0;
                end
              end
            end
            PH_EXTLEN: begin
              if (ext_bad) begin
                phase_d = PH_END;
              end else begin
                field_count_d = shift_next;
                phase_d       = (shift_next == '0) ? PH_SIZE : PH_EXT;
              end
            end
            PH_EXT: begin
              field_count_d = field_dec;
              if (field_dec == '0) begin
                phase_d = PH_SIZE;
              end
            end
            PH_SIZE: begin
              field_count_d = shift_next;
              phase_d       = (shift_next == '0) ? PH_END : PH_DATA;
            end
            PH_DATA: begin
              field_count_d = field_dec;
              if (field_dec == '0) begin
                phase_d = PH_END;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result of the current transaction
  // ---------------------------------------------------------------------------
  always_comb begin
    res_valid    = 1'b0;
    res.out_byte = 8'd0;
    res.kind     = KIND_STATUS;
    res.status   = ST_OK;
    res.last     = 1'b0;
    if (in_fire && (phase_q != PH_END)) begin
      if (in_end) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNC;
        res.last   = 1'b1;
      end else if (!header_wait && word_done) begin
        case (eff_phase)
          PH_MAGIC: begin
            if (!magic_ok) begin
              res_valid  = 1'b1;
              res.status = ST_MISMATCH;
              res.last   = 1'b1;
            end
          end
          PH_EXTLEN: begin
            if (ext_bad) begin
              res_valid  = 1'b1;
              res.status = ST_BADEXT;
              res.last   = 1'b1;
            end
          end
          PH_EXT: begin
            res_valid    = 1'b1;
            res.out_byte = ch;
            res.kind     = KIND_EXT;
          end
          PH_SIZE: begin
            // empty payload ends the stream right away
            if (shift_next == '0) begin
              res_valid  = 1'b1;
              res.status = ST_DONE;
              res.last   = 1'b1;
            end
          end
          PH_DATA: begin
            res_valid    = 1'b1;
            res.out_byte = ch;
            res.kind     = KIND_DATA;
            if (field_dec == '0) begin
              res.status = ST_DONE;
              res.last   = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      header_count_q <= '0;
      bit_count_q    <= '0;
      bit_shift_q    <= '0;
      field_count_q  <= '0;
    end else begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      bit_count_q    <= bit_count_d;
      bit_shift_q    <= bit_shift_d;
      field_count_q  <= field_count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register with skid stage
  // ---------------------------------------------------------------------------
  // input is held off only while the skid stage is occupied
  assign s_axis_tready = !skid_valid_q;
  assign out_taken     = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // no new transaction can arrive here; just drain the skid stage
      if (out_taken) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_taken) begin
      out_valid_q <= res_valid;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_taken) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_taken) begin
      if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.out_byte;
  assign m_axis_tuser  = {out_q.status, out_q.kind};
  assign m_axis_tlast  = out_q.last;

endmodule

FILE: hw/rtl/lspe_checker.sv
// port-level checker for the lsb stego payload extractor, with its bind
// depends on lspe_pkg and lsb_stego_payload_extractor_assert.svh
`timescale 1ns / 1ps

`include "lsb_stego_payload_extractor_assert.svh"

module lspe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lspe_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [lspe_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input logic                           m_axis_tlast
);

  import lspe_pkg::*;

  // set once the terminal transaction has left the block
  logic seen_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_last_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
      seen_last_q <= 1'b1;
    end
  end

  // a stalled result holds
  `LSPE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // nothing follows the terminal transaction
  `LSPE_ASSERT_IMPL(a_quiet_after_last, clk_i, rst_ni, seen_last_q, !m_axis_tvalid)

  // status-only results always close the stream
  `LSPE_ASSERT_IMPL(a_status_is_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[1:0] == KIND_STATUS), m_axis_tlast)

  // the closing transaction never reports busy
  `LSPE_ASSERT_IMPL(a_last_has_status, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser[4:2] != ST_OK)

endmodule

bind lsb_stego_payload_extractor lspe_checker u_lspe_checker (.*);

FILE: verif/lsb_stego_payload_extractor_tb.sv
// self-checking testbench for lsb_stego_payload_extractor
// drives one hidden stream bit by bit and checks each decoded transaction
// against a cycle-free model of the decoder; depends on lspe_pkg and the dut
`timescale 1ns / 1ps

module lsb_stego_payload_extractor_tb;
  import lspe_pkg::*;

  // run shape
  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 12;
  localparam int DRAIN_CYCLES    = 6;     // output register plus skid, with margin
  localparam int WATCHDOG_LIMIT  = 5000;  // cycles without any transaction or register write
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall to back up the input
  localparam int HEADER_ITEMS    = 20;
  localparam int PAYLOAD_BYTES   = 160;
  localparam int DIRECTED_BYTES  = 4;
  localparam int RANDOM_THIRD    = (PAYLOAD_BYTES - DIRECTED_BYTES) / 3;
  localparam int NOISE_ITEMS     = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // [7:0] image_byte
  logic [S_TUSER_W-1:0]  s_axis_tuser = '0;  // [0] stream_end

  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;       // [7:0] out_byte
  logic [M_TUSER_W-1:0]  m_axis_tuser;       // [1:0] kind, [4:2] status
  logic                  m_axis_tlast;

  lsb_stego_payload_extractor DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // idling profile, shared by the sender task and the receiver process
  int src_idle_pct  = 6;
  int snk_stall_pct = 75;
  int hold_off_left = 0;

  // bookkeeping
  res_t pending_results[$];
  int   err_count       = 0;
  int   items_sent      = 0;
  int   results_checked = 0;
  int   stall_cycles    = 0;
  bit   cut_short       = 1'b0;

  // decoder copy: registers as last written, plus the decode state
  logic [15:0] hdr_skip  = HEADER_SKIP_RST;
  logic [3:0]  mag_len   = MAGIC_LENGTH_RST;
  logic [63:0] mag_bytes = MAGIC_BYTES_RST;
  phase_e      dec_phase = PH_HEADER;
  logic [15:0] hdr_cnt   = '0;
  logic [4:0]  bit_cnt   = '0;
  logic [31:0] bit_acc   = '0;
  logic [31:0] fld_cnt   = '0;

  // ---------------------------------------------------------------------------
  // expected result construction
  // ---------------------------------------------------------------------------
  task automatic queue_result(input logic [7:0] chr, input kind_e knd, input status_e st,
                              input logic lst);
    res_t r;
    r.out_byte = chr;
    r.kind     = knd;
    r.status   = st;
    r.last     = lst;
    pending_results.push_back(r);
  endtask

  // any terminal status parks the decoder until reset
  task automatic close_stream(input status_e st);
    dec_phase = PH_END;
    queue_result(8'h00, KIND_STATUS, st, 1'b1);
  endtask

  // one accepted image byte through the decoder copy
  task automatic predict_decode(input logic [7:0] img, input logic fin);
    logic [3:0]  magic_used;
    logic [7:0]  chr;
    logic [31:0] word;
    int unsigned need;
    int unsigned sel;
    magic_used = (mag_len > MAGIC_MAX_BYTES) ? 4'(MAGIC_MAX_BYTES) : mag_len;
    if (dec_phase == PH_END) return;
    if (fin) begin
      close_stream(ST_TRUNC);
      return;
    end
    if (dec_phase == PH_HEADER) begin
      if (hdr_cnt < hdr_skip) begin
        hdr_cnt = hdr_cnt + 16'd1;
        return;
      end
      // the byte that ends the header already carries the first hidden bit
      dec_phase = (magic_used == 4'd0) ? PH_EXTLEN : PH_MAGIC;
      fld_cnt   = '0;
      bit_cnt   = '0;
      bit_acc   = '0;
    end
    bit_acc = {bit_acc[30:0], img[0]};
    need = (dec_phase == PH_EXTLEN || dec_phase == PH_SIZE) ? SIZE_BITS : 8;
    if (32'(bit_cnt) + 32'd1 < need) begin
      bit_cnt = bit_cnt + 5'd1;
      return;
    end
    bit_cnt = '0;
    chr     = bit_acc[7:0];
    word    = 32'({32'd0, bit_acc} & ((64'd1 << SIZE_BITS) - 64'd1));
    bit_acc = '0;
    case (dec_phase)
      PH_MAGIC: begin
        // first magic character sits in the top byte
        sel = 63 - 8 * int'(fld_cnt[2:0]);
        if (chr != mag_bytes[sel -: 8]) begin
          close_stream(ST_MISMATCH);
        end else begin
          fld_cnt = fld_cnt + 32'd1;
          if (fld_cnt >= 32'(magic_used)) begin
            dec_phase = PH_EXTLEN;
            fld_cnt   = '0;
          end
        end
      end
      PH_EXTLEN: begin
        if (word > MAX_EXTENSION) begin
          close_stream(ST_BADEXT);
        end else begin
          fld_cnt   = word;
          dec_phase = (word == 32'd0) ? PH_SIZE : PH_EXT;
        end
      end
      PH_EXT: begin
        fld_cnt = fld_cnt - 32'd1;
        if (fld_cnt == 32'd0) dec_phase = PH_SIZE;
        queue_result(chr, KIND_EXT, ST_OK, 1'b0);
      end
      PH_SIZE: begin
        fld_cnt = word;
        if (word == 32'd0) close_stream(ST_DONE);
        else dec_phase = PH_DATA;
      end
      default: begin
        fld_cnt = fld_cnt - 32'd1;
        if (fld_cnt == 32'd0) begin
          dec_phase = PH_END;
          queue_result(chr, KIND_DATA, ST_DONE, 1'b1);
        end else begin
          queue_result(chr, KIND_DATA, ST_OK, 1'b0);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // one image byte transaction, with a random gap in front of it
  // tvalid is left high after acceptance so back-to-back items never toggle it
  task automatic send_image_byte(input logic [7:0] img, input logic fin);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= img;
    s_axis_tuser  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    predict_decode(img, fin);
  endtask

  // hide one value in the lsbs, msb first; upper bits of each byte are random
  task automatic send_bits(input logic [31:0] value, input int nbits);
    logic [7:0] img;
    for (int b = nbits - 1; b >= 0; b--) begin
      img    = 8'($urandom);
      img[0] = value[b];
      send_image_byte(img, 1'b0);
    end
  endtask

  // register write; the enable is lowered by the next send or drain
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CFG_HEADER_SKIP:  hdr_skip  = value[15:0];
      CFG_MAGIC_LENGTH: mag_len   = value[3:0];
      CFG_MAGIC_BYTES:  mag_bytes = value;
      default: ;
    endcase
  endtask

  // stop offering, let every pending result out, then let the pipe settle
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // test tasks, one per stage of the hidden stream
  // ---------------------------------------------------------------------------

  // header skip at its maximum, then dropped to zero under the running count
  task automatic test_header_skip();
    logic [63:0] magic;
    magic = {8'h00, 8'hFF, 16'($urandom), 32'($urandom)};
    write_register(CFG_HEADER_SKIP, 64'hFFFF);
    write_register(CFG_MAGIC_LENGTH, 64'd15);  // above the maximum, saturates
    write_register(CFG_MAGIC_BYTES, magic);
    repeat (HEADER_ITEMS) send_image_byte(8'($urandom), 1'b0);
    drain_block();
    // count is already past zero: the next byte leaves the header
    write_register(CFG_HEADER_SKIP, 64'd0);
  endtask

  // full saturated magic, every character matching, no transactions expected
  task automatic test_magic();
    for (int i = 0; i < MAGIC_MAX_BYTES; i++) send_bits(32'(mag_bytes[63 - 8 * i -: 8]), 8);
    drain_block();
    // magic phase is over, these writes must not disturb the decode
    write_register(CFG_MAGIC_LENGTH, 64'd0);
    write_register(CFG_MAGIC_BYTES, 64'd0);
  endtask

  // extension length at its maximum with extreme and random characters
  task automatic test_extension();
    send_bits(32'(MAX_EXTENSION), SIZE_BITS);
    for (int i = 0; i < MAX_EXTENSION; i++) begin
      case (i)
        0:       send_bits(32'h00, 8);
        1:       send_bits(32'hFF, 8);
        default: send_bits(32'($urandom_range(255)), 8);
      endcase
    end
  endtask

  // long payload: directed extremes, then random bytes under three idling
  // profiles; the stream ends either on the last byte or by an early end flag
  task automatic test_payload();
    int unsigned tail_bits;
    logic [7:0]  data;
    cut_short = 1'($urandom_range(1));
    send_bits(32'(PAYLOAD_BYTES), SIZE_BITS);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (i == DIRECTED_BYTES) begin
        // receiver holds off long enough for the output side to fill up
        set_idling(6, 75);
        hold_off_left = HOLD_OFF_CYCLES;
      end else if (i == DIRECTED_BYTES + RANDOM_THIRD) begin
        set_idling(75, 6);
      end else if (i == DIRECTED_BYTES + 2 * RANDOM_THIRD) begin
        set_idling(0, 0);
      end
      case (i)
        0:       data = 8'h00;
        1:       data = 8'hFF;
        2:       data = 8'h80;
        3:       data = 8'h01;
        default: data = 8'($urandom);
      endcase
      if (cut_short && i == PAYLOAD_BYTES - 1) begin
        tail_bits = $urandom_range(7);
        repeat (tail_bits) send_image_byte(8'($urandom), 1'b0);
        send_image_byte(8'($urandom), 1'b1);
      end else begin
        send_bits(32'(data), 8);
      end
    end
    drain_block();
  endtask

  // terminal state: writes and any input, end flag included, give nothing
  task automatic test_after_end();
    write_register(CFG_HEADER_SKIP, 64'($urandom_range(65534, 1)));
    write_register(CFG_MAGIC_LENGTH, 64'(MAGIC_MAX_BYTES));
    write_register(CFG_MAGIC_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    set_idling(6, 75);
    repeat (NOISE_ITEMS) send_image_byte(8'($urandom), 1'($urandom_range(3) == 0));
    send_image_byte(8'($urandom), 1'b1);
    drain_block();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, or a counted hold-off when one is requested
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction byte %02h tuser %02h last %0b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_axis_tdata !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h", m_axis_tdata, want.out_byte));
        if (m_axis_tuser[1:0] !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %s", m_axis_tuser[1:0], want.kind.name()));
        if (m_axis_tuser[4:2] !== want.status)
          report_mismatch($sformatf("status %0d, expected %s", m_axis_tuser[4:2],
                                    want.status.name()));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", m_axis_tlast, want.last));
      end
    end
  end

  // watchdog: any transaction or register write counts as progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence: one reset, one hidden stream from header to terminal status
  // ---------------------------------------------------------------------------
  initial begin
    set_idling(6, 75);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_skip();
    test_magic();
    test_extension();
    test_payload();
    test_after_end();

    $display("covered %0d image bytes and %0d decoded transactions, stream ended by %s",
             items_sent, results_checked, cut_short ? "early end flag" : "last payload byte");
    $display("register extremes, saturated magic, full extension, input back-pressure");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/lspe_pkg.sv
hw/rtl/lsb_stego_payload_extractor.sv
hw/rtl/lspe_checker.sv
verif/lsb_stego_payload_extractor_tb.sv
